// File: hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// When the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  `ASSERT_CLK(label, (ante) |-> (cons), msg)

// When the antecedent holds, the consequent must hold in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  `ASSERT_CLK(label, (ante) |=> (cons), msg)

`endif

// File: hw/rtl/iss_pkg.sv
// ---------------------------------------------------------------------------
// iss_pkg
// Types, codes and constants of the idle, backlight and sleep sequencer.
// ---------------------------------------------------------------------------
package iss_pkg;

  localparam int TIMER_BITS_DEF = 20;
  localparam int CFG_W          = 20;
  localparam int TIME_W         = 48;
  localparam int TYPE_W         = 5;
  localparam int CODE_W         = 10;
  localparam int VALUE_W        = 32;
  localparam int ADDR_W         = 5;
  localparam int DATA_W         = 32;
  localparam int REG_IDX_W      = 3;

  // Input event codes.
  localparam logic [TYPE_W-1:0] EVT_KEY        = 5'h01;
  localparam logic [TYPE_W-1:0] EVT_SWITCH     = 5'h05;
  localparam logic [TYPE_W-1:0] EVT_POWER      = 5'h16;
  localparam logic [CODE_W-1:0] CODE_POWER_KEY = 10'd116;
  localparam logic [CODE_W-1:0] CODE_SLEEP     = 10'd142;
  localparam logic [CODE_W-1:0] CODE_LID       = 10'd0;

  typedef enum logic [1:0] {
    FUNC_TICK   = 2'd0,
    FUNC_EVENT  = 2'd1,
    FUNC_CHARGE = 2'd2,
    FUNC_START  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    CHG_UNKNOWN     = 2'd0,
    CHG_DISCHARGING = 2'd1,
    CHG_CHARGING    = 2'd2
  } charge_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_IDLE_TICKS     = 3'd0,
    REG_LCD_TICKS      = 3'd1,
    REG_KEY_TICKS      = 3'd2,
    REG_RESLEEP_TICKS  = 3'd3,
    REG_ACTIVITY_REP   = 3'd4,
    REG_STAMP_SLEEP    = 3'd5,
    REG_START_AWAKE    = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [CFG_W-1:0] idle_ticks;
    logic [CFG_W-1:0] lcd_light_ticks;
    logic [CFG_W-1:0] key_light_ticks;
    logic [CFG_W-1:0] resleep_ticks;
    logic             activity_reporting;
    logic             stamp_sleep;
    logic             start_awake;
  } cfg_t;

  typedef struct packed {
    logic              lcd_light_change;
    logic              lcd_light_level;
    logic              key_light_change;
    logic              key_light_level;
    logic              activity_report;
    logic [TIME_W-1:0] activity_time_us;
    logic              sleep_request;
    logic              sleep_with_stamp;
    logic [TIME_W-1:0] sleep_time_us;
    logic              full_wake;
  } res_t;

endpackage

// File: hw/rtl/iss_cfg_regs.sv
// ---------------------------------------------------------------------------
// iss_cfg_regs
// APB-style configuration register file of the sequencer.
// ---------------------------------------------------------------------------
module iss_cfg_regs
  import iss_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.idle_ticks         <= CFG_W'(50);
      cfg.lcd_light_ticks    <= '0;
      cfg.key_light_ticks    <= '0;
      cfg.resleep_ticks      <= CFG_W'(5);
      cfg.activity_reporting <= 1'b0;
      cfg.stamp_sleep        <= 1'b1;
      cfg.start_awake        <= 1'b1;
    end else if (wr_en) begin
      unique case (idx)
        REG_IDLE_TICKS:    cfg.idle_ticks         <= pwdata[CFG_W-1:0];
        REG_LCD_TICKS:     cfg.lcd_light_ticks    <= pwdata[CFG_W-1:0];
        REG_KEY_TICKS:     cfg.key_light_ticks    <= pwdata[CFG_W-1:0];
        REG_RESLEEP_TICKS: cfg.resleep_ticks      <= pwdata[CFG_W-1:0];
        REG_ACTIVITY_REP:  cfg.activity_reporting <= pwdata[0];
        REG_STAMP_SLEEP:   cfg.stamp_sleep        <= pwdata[0];
        REG_START_AWAKE:   cfg.start_awake        <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_IDLE_TICKS:    prdata = DATA_W'(cfg.idle_ticks);
      REG_LCD_TICKS:     prdata = DATA_W'(cfg.lcd_light_ticks);
      REG_KEY_TICKS:     prdata = DATA_W'(cfg.key_light_ticks);
      REG_RESLEEP_TICKS: prdata = DATA_W'(cfg.resleep_ticks);
      REG_ACTIVITY_REP:  prdata = DATA_W'(cfg.activity_reporting);
      REG_STAMP_SLEEP:   prdata = DATA_W'(cfg.stamp_sleep);
      REG_START_AWAKE:   prdata = DATA_W'(cfg.start_awake);
      default:           prdata = '0;
    endcase
  end

endmodule

// File: hw/rtl/iss_core.sv
// ---------------------------------------------------------------------------
// iss_core
// Input register, sequencer state and the single-pass update logic.
// ---------------------------------------------------------------------------
module iss_core
  import iss_pkg::*;
#(
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         func,
  input  logic [TYPE_W-1:0]  event_type,
  input  logic [CODE_W-1:0]  event_code,
  input  logic signed [VALUE_W-1:0] event_value,
  input  logic [TIME_W-1:0]  event_time_us,
  input  logic               charging,
  output logic               res_valid,
  input  logic               res_ready,
  output res_t               res
);

  // Loads are at most one bit wider than a configuration register.
  localparam int LW = (TIMER_BITS > CFG_W + 1) ? TIMER_BITS : CFG_W + 1;
  localparam logic [LW-1:0] TMAX = LW'((64'd1 << TIMER_BITS) - 64'd1);

  function automatic logic [TIMER_BITS-1:0] sat_load(input logic [LW-1:0] v);
    sat_load = (v > TMAX) ? TMAX[TIMER_BITS-1:0] : v[TIMER_BITS-1:0];
  endfunction

  // Input register.
  logic                      in_vld;
  func_t                     q_func;
  logic [TYPE_W-1:0]         q_type;
  logic [CODE_W-1:0]         q_code;
  logic signed [VALUE_W-1:0] q_value;
  logic [TIME_W-1:0]         q_time;
  logic                      q_charging;
  logic                      advance;

  assign advance   = in_vld & res_ready;
  assign in_ready  = ~in_vld | res_ready;
  assign res_valid = in_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (in_ready) begin
      in_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      q_func     <= func_t'(func);
      q_type     <= event_type;
      q_code     <= event_code;
      q_value    <= event_value;
      q_time     <= event_time_us;
      q_charging <= charging;
    end
  end

  // Sequencer state.
  logic                  running, running_next;
  logic [TIMER_BITS-1:0] timer, timer_next;
  logic                  lcd_on, lcd_on_next;
  logic                  key_on, key_on_next;
  logic                  power_key_held, power_key_held_next;
  logic                  woke_from_sleep, woke_from_sleep_next;
  logic [TIME_W-1:0]     stamp, stamp_next;
  charge_t               charge_state, charge_state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      running         <= 1'b0;
      timer           <= '0;
      lcd_on          <= 1'b0;
      key_on          <= 1'b0;
      power_key_held  <= 1'b0;
      woke_from_sleep <= 1'b0;
      stamp           <= '0;
      charge_state    <= CHG_UNKNOWN;
    end else if (advance) begin
      running         <= running_next;
      timer           <= timer_next;
      lcd_on          <= lcd_on_next;
      key_on          <= key_on_next;
      power_key_held  <= power_key_held_next;
      woke_from_sleep <= woke_from_sleep_next;
      stamp           <= stamp_next;
      charge_state    <= charge_state_next;
    end
  end

  // Update logic.
  logic [CFG_W:0]        key_ext;
  logic [CFG_W:0]        lcd_eff;
  logic [TIMER_BITS-1:0] tick_dec;
  logic                  is_switch;
  logic                  is_active;
  logic                  lid_close;
  charge_t               charge_new;

  always_comb begin
    key_ext    = {1'b0, cfg.key_light_ticks};
    lcd_eff    = (cfg.key_light_ticks >= cfg.lcd_light_ticks) ?
                 key_ext + (CFG_W+1)'(1) : {1'b0, cfg.lcd_light_ticks};
    tick_dec   = (timer != '0) ? timer - TIMER_BITS'(1) : timer;
    is_switch  = (q_type == EVT_SWITCH) && (q_code == CODE_LID);
    is_active  = (q_type == EVT_KEY) || (is_switch && (q_value == 32'sd1));
    lid_close  = is_switch && (q_value == 32'sd0);
    charge_new = q_charging ? CHG_CHARGING : CHG_DISCHARGING;

    running_next         = running;
    timer_next           = timer;
    lcd_on_next          = lcd_on;
    key_on_next          = key_on;
    power_key_held_next  = power_key_held;
    woke_from_sleep_next = woke_from_sleep;
    stamp_next           = stamp;
    charge_state_next    = charge_state;
    res                  = '0;

    unique case (q_func)
      FUNC_START: begin
        running_next         = 1'b1;
        lcd_on_next          = 1'b0;
        key_on_next          = 1'b0;
        power_key_held_next  = 1'b0;
        woke_from_sleep_next = 1'b0;
        stamp_next           = '0;
        timer_next = sat_load(LW'(cfg.start_awake ? cfg.idle_ticks : cfg.resleep_ticks));
      end
      FUNC_TICK: begin
        if (running) begin
          timer_next = tick_dec;
          if (tick_dec == '0) begin
            if (key_on) begin
              key_on_next          = 1'b0;
              res.key_light_change = 1'b1;
              timer_next           = sat_load(LW'(lcd_eff - key_ext));
            end else if (lcd_on) begin
              lcd_on_next          = 1'b0;
              res.lcd_light_change = 1'b1;
              timer_next = ({1'b0, cfg.idle_ticks} > lcd_eff) ?
                           sat_load(LW'({1'b0, cfg.idle_ticks} - lcd_eff)) : '0;
            end else if (!cfg.activity_reporting) begin
              // Both lights are already off here, so only the request goes out.
              res.sleep_request    = 1'b1;
              res.sleep_with_stamp = cfg.stamp_sleep;
              res.sleep_time_us    = stamp;
              timer_next           = sat_load(LW'(cfg.resleep_ticks));
            end else begin
              timer_next = sat_load(LW'(cfg.idle_ticks));
            end
          end
        end
      end
      FUNC_EVENT: begin
        if (running) begin
          if ((q_type == EVT_POWER) && (q_code == CODE_SLEEP)) begin
            woke_from_sleep_next = (q_value != 32'sd0);
          end
          if (is_active) begin
            if (cfg.activity_reporting) begin
              res.activity_report  = 1'b1;
              res.activity_time_us = q_time;
            end
            timer_next           = sat_load(LW'(cfg.key_light_ticks));
            lcd_on_next          = 1'b1;
            key_on_next          = 1'b1;
            res.lcd_light_change = 1'b1;
            res.lcd_light_level  = 1'b1;
            res.key_light_change = 1'b1;
            res.key_light_level  = 1'b1;
            if (q_code == CODE_POWER_KEY) begin
              if (q_value == 32'sd0) begin
                power_key_held_next = 1'b0;
                if (power_key_held) begin
                  // Release after a press: lights were just lit, so both go off again.
                  lcd_on_next          = 1'b0;
                  key_on_next          = 1'b0;
                  res.lcd_light_level  = 1'b0;
                  res.key_light_level  = 1'b0;
                  res.sleep_request    = 1'b1;
                  res.sleep_with_stamp = cfg.stamp_sleep;
                  res.sleep_time_us    = stamp;
                  timer_next           = sat_load(LW'(cfg.resleep_ticks));
                end
              end else if (!woke_from_sleep) begin
                power_key_held_next = 1'b1;
                stamp_next          = q_time;
              end
            end
          end
          if (lid_close) begin
            stamp_next = q_time;
            if (lcd_on) begin
              lcd_on_next          = 1'b0;
              key_on_next          = 1'b0;
              res.lcd_light_change = 1'b1;
              res.key_light_change = 1'b1;
            end
            res.sleep_request    = 1'b1;
            res.sleep_with_stamp = cfg.stamp_sleep;
            res.sleep_time_us    = q_time;
            timer_next           = sat_load(LW'(cfg.resleep_ticks));
          end
        end
      end
      FUNC_CHARGE: begin
        if (running) begin
          res.full_wake     = (charge_new > charge_state);
          charge_state_next = charge_new;
        end
      end
      default: ;
    endcase
  end

endmodule

// File: hw/rtl/iss_out_reg.sv
// ---------------------------------------------------------------------------
// iss_out_reg
// Result register between the update logic and the output channel.
// ---------------------------------------------------------------------------
module iss_out_reg
  import iss_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic res_valid,
  output logic res_ready,
  input  res_t res,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_res
);

  logic load;

  assign res_ready = ~out_valid | out_ready;
  assign load      = res_valid & res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res <= res;
    end
  end

endmodule

// File: hw/rtl/idle_backlight_sleep_sequencer_top.sv
// Pipeline: an accepted beat sits in the input register, moves into the result
// register once that register is free and leaves from there on the output channel.
// Throughput: one beat per cycle unless out_ready stalls the output; the update of
// the timer and light state is a single combinational pass between the two registers.
// Reset: synchronous, active high; clears state, restores register defaults and
// leaves the sequencer stopped until a start beat arrives.
// ---------------------------------------------------------------------------
// idle_backlight_sleep_sequencer_top
// Idle timer, backlight and sleep-request sequencer with APB-style config.
// ---------------------------------------------------------------------------
module idle_backlight_sleep_sequencer_top
  import iss_pkg::*;
#(
  // Width of the idle timer; loads saturate at its all-ones value.
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  // Configuration port.
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [ADDR_W-1:0]         paddr,
  input  logic [DATA_W-1:0]         pwdata,
  output logic [DATA_W-1:0]         prdata,
  output logic                      pready,
  // Input channel.
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                func,
  input  logic [TYPE_W-1:0]         event_type,
  input  logic [CODE_W-1:0]         event_code,
  input  logic signed [VALUE_W-1:0] event_value,
  input  logic [TIME_W-1:0]         event_time_us,
  input  logic                      charging,
  // Output channel.
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      lcd_light_change,
  output logic                      lcd_light_level,
  output logic                      key_light_change,
  output logic                      key_light_level,
  output logic                      activity_report,
  output logic [TIME_W-1:0]         activity_time_us,
  output logic                      sleep_request,
  output logic                      sleep_with_stamp,
  output logic [TIME_W-1:0]         sleep_time_us,
  output logic                      full_wake
);

  // The register file feeds the update logic directly, with no shadow copy kept.
  // Software must write it only while no beat is in flight; this is not enforced.
  cfg_t cfg;

  // Handshake between the update stage and the result register. The result
  // register frees itself in the same cycle that its beat leaves, so a full
  // pipeline still moves one beat per cycle while out_ready stays high.
  logic res_valid;
  logic res_ready;
  res_t res;
  res_t out_res;

  iss_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // The core registers each input beat, then computes the result beat and the
  // next sequencer state in one pass. State commits when the result beat moves
  // into the result register, so stalls never update the state twice.
  iss_core #(
    .TIMER_BITS (TIMER_BITS)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .func          (func),
    .event_type    (event_type),
    .event_code    (event_code),
    .event_value   (event_value),
    .event_time_us (event_time_us),
    .charging      (charging),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res           (res)
  );

  iss_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  // Fields that carry no meaning in a beat are zero, as built by the core.
  assign lcd_light_change = out_res.lcd_light_change;
  assign lcd_light_level  = out_res.lcd_light_level;
  assign key_light_change = out_res.key_light_change;
  assign key_light_level  = out_res.key_light_level;
  assign activity_report  = out_res.activity_report;
  assign activity_time_us = out_res.activity_time_us;
  assign sleep_request    = out_res.sleep_request;
  assign sleep_with_stamp = out_res.sleep_with_stamp;
  assign sleep_time_us    = out_res.sleep_time_us;
  assign full_wake        = out_res.full_wake;

endmodule

// File: hw/rtl/iss_checker.sv
// ---------------------------------------------------------------------------
// iss_checker
// Port-level checks of the sequencer, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module iss_checker
  import iss_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input logic              lcd_light_change,
  input logic              lcd_light_level,
  input logic              key_light_change,
  input logic              key_light_level,
  input logic              sleep_request,
  input logic              sleep_with_stamp,
  input logic [TIME_W-1:0] sleep_time_us
);

  // A stalled beat keeps its sleep request and sleep time.
  `ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(sleep_time_us) && $stable(sleep_request), "stalled output beat changed")

  // A level is only meaningful with its change flag.
  `ASSERT_IMPLIES(a_level_flag, out_valid && (lcd_light_level || key_light_level), (lcd_light_change || !lcd_light_level) && (key_light_change || !key_light_level), "light level without change flag")

  `ASSERT_IMPLIES(a_stamp_flag, out_valid && sleep_with_stamp, sleep_request, "stamp flag without sleep request")

  // A sleep request that commands the LCD turns both lights off.
  `ASSERT_IMPLIES(a_sleep_dark, out_valid && sleep_request && lcd_light_change, !lcd_light_level && key_light_change && !key_light_level, "sleep left a light on")

endmodule

bind idle_backlight_sleep_sequencer_top iss_checker u_iss_checker (.*);
